[hdl/lfmd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line follower motor drive package
// Shared types, register codes and fixed-point constants of the motor drive.
// ----------------------------------------------------------------------------
package lfmd_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_LINE_IS_WHITE = 2'd0,
    CFG_DIGITAL_SCAN  = 2'd1,
    CFG_SPEED_PERCENT = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned PercentW  = 7;
  localparam int unsigned SampleW   = 10;
  localparam int unsigned DriveW    = 8;
  localparam int unsigned PatternW  = 5;

  localparam logic [PercentW-1:0] PercentMax   = 7'd100;
  localparam logic [PercentW-1:0] PercentReset = 7'd100;

  // floor(x / 100) for x below 25600 as (x * 5243) >> 19.
  localparam logic [12:0] DivHundredMul = 13'd5243;
  // floor(x / 10) for x below 2048 as (x * 6554) >> 16.
  localparam logic [12:0] DivTenMul     = 13'd6554;

  typedef struct packed {
    logic                line_is_white;
    logic                digital_scan;
    logic [PercentW-1:0] speed_percent;
  } cfg_t;

  function automatic logic [7:0] div10(input logic [10:0] x);
    logic [23:0] prod;
    prod = 24'(x) * 24'(DivTenMul);
    return prod[23:16];
  endfunction

endpackage
`default_nettype wire

[hdl/lfmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line follower motor drive channels
// Valid/ready channels for sensor sample sets and motor drive results.
// ----------------------------------------------------------------------------
interface lfmd_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] sample_far_left;
  logic [9:0] sample_near_left;
  logic [9:0] sample_centre;
  logic [9:0] sample_near_right;
  logic [9:0] sample_far_right;
  logic [4:0] sensor_bits;

  modport source (
    output valid, sample_far_left, sample_near_left, sample_centre,
           sample_near_right, sample_far_right, sensor_bits,
    input  ready
  );
  modport sink (
    input  valid, sample_far_left, sample_near_left, sample_centre,
           sample_near_right, sample_far_right, sensor_bits,
    output ready
  );
endinterface

interface lfmd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] right_drive;
  logic [7:0] left_drive;
  logic [4:0] line_pattern;

  modport source (
    output valid, right_drive, left_drive, line_pattern,
    input  ready
  );
  modport sink (
    input  valid, right_drive, left_drive, line_pattern,
    output ready
  );
endinterface
`default_nettype wire

[hdl/lfmd_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line follower motor drive configuration registers
// Write-only register file for line colour, scan mode and peak speed.
// ----------------------------------------------------------------------------
module lfmd_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lfmd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lfmd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output lfmd_pkg::cfg_t                     cfg_o
);

  lfmd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lfmd_pkg::CFG_LINE_IS_WHITE: cfg_d.line_is_white = cfg_wdata_i[0];
        lfmd_pkg::CFG_DIGITAL_SCAN:  cfg_d.digital_scan  = cfg_wdata_i[0];
        lfmd_pkg::CFG_SPEED_PERCENT: cfg_d.speed_percent = cfg_wdata_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_is_white <= 1'b0;
      cfg_q.digital_scan  <= 1'b0;
      cfg_q.speed_percent <= lfmd_pkg::PercentReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[hdl/line_follower_motor_drive.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line follower motor drive
// Turns one set of line-sensor readings into right and left PWM duty values.
// ----------------------------------------------------------------------------
// Usage
//   Sample sets enter on in_i, one transaction per set of five analog samples
//   and the digital sensor pattern. Each accepted transaction yields exactly
//   one result transaction on out_o carrying both motor duties and, in
//   digital mode, the normalised line pattern (zero in analog mode).
//   The configuration port, with no read-back, takes one register write
//   per clock; the user writes only with no transaction held (unenforced).
// Pipeline and throughput
//   The set passes one register per pipeline stage, the first loaded at
//   the accepting edge and the last driving out_o: peak speed, speed
//   fractions, sample products, division by full scale, side saturation,
//   then the two cross-cut steps.
//   One transaction is accepted in every cycle when the receiver keeps up.
// Reset
//   Reset empties the pipeline and restores black line, analog mode and
//   full speed (100 percent).
// Stalls
//   Each stage moves on whenever the stage after it is empty or moving, so a
//   stalled receiver only backs up the pipeline; bubbles are squeezed out
//   and the input keeps being accepted until all seven stages are full.
// ----------------------------------------------------------------------------
module line_follower_motor_drive #(
  parameter int unsigned SAMPLE_FULL_SCALE = 850
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lfmd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lfmd_pkg::CfgDataW-1:0] cfg_wdata_i,
  lfmd_in_if.sink                            in_i,
  lfmd_out_if.source                         out_o
);

  // Division by the full scale is a multiplication by a rounded-up
  // reciprocal. With a 28-bit shift the error stays well below one part in
  // the full scale for every product below 2^18, so the quotient is exact.
  localparam int unsigned RecipShift = 28;
  localparam int unsigned RecipInt   =
      ((1 << RecipShift) + SAMPLE_FULL_SCALE - 1) / SAMPLE_FULL_SCALE;
  localparam logic [28:0] RecipMul   = 29'(RecipInt);

  localparam int unsigned NumStages = 7;
  localparam int unsigned ProdW     = 18;  // sample times weight
  localparam int unsigned ScaledW   = 18;  // quotient, below 2^18 at scale one

  // Digital line patterns after normalisation to a dark line.
  localparam logic [4:0] PatCentre      = 5'd4;
  localparam logic [4:0] PatRightSoft   = 5'd12;
  localparam logic [4:0] PatRightMid    = 5'd8;
  localparam logic [4:0] PatRightHard   = 5'd24;
  localparam logic [4:0] PatRightEdge   = 5'd16;
  localparam logic [4:0] PatRightWide   = 5'd28;
  localparam logic [4:0] PatRightWidest = 5'd30;
  localparam logic [4:0] PatLeftSoft    = 5'd6;
  localparam logic [4:0] PatLeftMid     = 5'd2;
  localparam logic [4:0] PatLeftHard    = 5'd3;
  localparam logic [4:0] PatLeftEdge    = 5'd1;
  localparam logic [4:0] PatLeftWide    = 5'd7;
  localparam logic [4:0] PatLeftWidest  = 5'd15;

  // Control carried alongside each transaction from stage two onwards.
  typedef struct packed {
    logic        white;
    logic        digital;
    logic [7:0]  m;
    logic [10:0] m8;
    logic [7:0]  dig_right;
    logic [7:0]  dig_left;
    logic [4:0]  pattern;
  } ctl_t;

  typedef struct packed {
    logic       white;
    logic       digital;
    logic [7:0] m;
    logic [4:0] pattern;
    logic [9:0] s0;
    logic [9:0] s1;
    logic [9:0] s3;
    logic [9:0] s4;
  } st1_t;

  typedef struct packed {
    ctl_t       ctl;
    logic [7:0] k_outer;
    logic [7:0] k_inner;
    logic [9:0] s0;
    logic [9:0] s1;
    logic [9:0] s3;
    logic [9:0] s4;
  } st2_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [ProdW-1:0] p0;
    logic [ProdW-1:0] p1;
    logic [ProdW-1:0] p3;
    logic [ProdW-1:0] p4;
  } st3_t;

  typedef struct packed {
    ctl_t               ctl;
    logic [ScaledW-1:0] a0;
    logic [ScaledW-1:0] a1;
    logic [ScaledW-1:0] a3;
    logic [ScaledW-1:0] a4;
  } st4_t;

  typedef struct packed {
    ctl_t       ctl;
    logic [7:0] lw;
    logic [7:0] rw;
  } st56_t;

  typedef struct packed {
    ctl_t       ctl;
    logic [7:0] right;
    logic [7:0] left;
  } st7_t;

  lfmd_pkg::cfg_t cfg;

  lfmd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // --------------------------------------------------------------------------
  // Handshake: a stage loads when it is empty or the stage after it loads.
  // --------------------------------------------------------------------------
  logic [NumStages:1]   vld_q;
  logic [NumStages+1:1] adv;

  always_comb begin
    adv[NumStages+1] = out_o.ready;
    for (int i = NumStages; i >= 1; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign in_i.ready = adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[1]) begin
        vld_q[1] <= in_i.valid;
      end
      for (int i = 2; i <= NumStages; i++) begin
        if (adv[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage one: peak speed m = floor(255 * percent / 100), pattern normalised.
  // --------------------------------------------------------------------------
  logic [6:0]  pct_sat;
  logic [14:0] pct_x255;
  logic [27:0] m_prod;
  st1_t        st1_d, st1_q;

  always_comb begin
    pct_sat  = (cfg.speed_percent > lfmd_pkg::PercentMax) ? lfmd_pkg::PercentMax
                                                            : cfg.speed_percent;
    pct_x255 = {pct_sat, 8'd0} - 15'(pct_sat);
    m_prod   = 28'(pct_x255) * 28'(lfmd_pkg::DivHundredMul);

    st1_d.white   = cfg.line_is_white;
    st1_d.digital = cfg.digital_scan;
    st1_d.m       = m_prod[26:19];
    // The pattern is only reported in digital mode; a white line is inverted
    // so the table always sees a dark line.
    if (!cfg.digital_scan) begin
      st1_d.pattern = '0;
    end else if (cfg.line_is_white) begin
      st1_d.pattern = ~in_i.sensor_bits;
    end else begin
      st1_d.pattern = in_i.sensor_bits;
    end
    st1_d.s0 = in_i.sample_far_left;
    st1_d.s1 = in_i.sample_near_left;
    st1_d.s3 = in_i.sample_near_right;
    st1_d.s4 = in_i.sample_far_right;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      st1_q <= st1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage two: sensor weights, the tenths of m and the digital table.
  // --------------------------------------------------------------------------
  logic [7:0] m_4_5, m_3_5, m_2_5;
  st2_t       st2_d, st2_q;

  always_comb begin
    m_4_5 = lfmd_pkg::div10({st1_q.m, 3'd0});
    m_3_5 = lfmd_pkg::div10(11'({st1_q.m, 2'd0}) + 11'({st1_q.m, 1'd0}));
    m_2_5 = lfmd_pkg::div10(11'({st1_q.m, 2'd0}));

    st2_d.k_outer = lfmd_pkg::div10({st1_q.m, 3'd0} - 11'(st1_q.m));
    st2_d.k_inner = lfmd_pkg::div10(11'({st1_q.m, 1'd0}) + 11'(st1_q.m));

    st2_d.ctl.white   = st1_q.white;
    st2_d.ctl.digital = st1_q.digital;
    st2_d.ctl.m       = st1_q.m;
    st2_d.ctl.m8      = {st1_q.m, 3'd0};
    st2_d.ctl.pattern = st1_q.pattern;

    case (st1_q.pattern)
      PatCentre: begin
        st2_d.ctl.dig_right = st1_q.m;
        st2_d.ctl.dig_left  = st1_q.m;
      end
      PatRightSoft: begin
        st2_d.ctl.dig_right = m_4_5;
        st2_d.ctl.dig_left  = st1_q.m;
      end
      PatRightMid: begin
        st2_d.ctl.dig_right = m_3_5;
        st2_d.ctl.dig_left  = st1_q.m;
      end
      PatRightHard: begin
        st2_d.ctl.dig_right = m_2_5;
        st2_d.ctl.dig_left  = st1_q.m;
      end
      PatRightEdge, PatRightWide, PatRightWidest: begin
        st2_d.ctl.dig_right = '0;
        st2_d.ctl.dig_left  = st1_q.m;
      end
      PatLeftSoft: begin
        st2_d.ctl.dig_right = st1_q.m;
        st2_d.ctl.dig_left  = m_4_5;
      end
      PatLeftMid: begin
        st2_d.ctl.dig_right = st1_q.m;
        st2_d.ctl.dig_left  = m_3_5;
      end
      PatLeftHard: begin
        st2_d.ctl.dig_right = st1_q.m;
        st2_d.ctl.dig_left  = m_2_5;
      end
      PatLeftEdge, PatLeftWide, PatLeftWidest: begin
        st2_d.ctl.dig_right = st1_q.m;
        st2_d.ctl.dig_left  = '0;
      end
      default: begin
        st2_d.ctl.dig_right = '0;
        st2_d.ctl.dig_left  = '0;
      end
    endcase

    st2_d.s0 = st1_q.s0;
    st2_d.s1 = st1_q.s1;
    st2_d.s3 = st1_q.s3;
    st2_d.s4 = st1_q.s4;
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      st2_q <= st2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage three: each of the four side samples times its weight.
  // --------------------------------------------------------------------------
  st3_t st3_d, st3_q;

  always_comb begin
    st3_d.ctl = st2_q.ctl;
    st3_d.p0  = ProdW'(st2_q.s0) * ProdW'(st2_q.k_outer);
    st3_d.p1  = ProdW'(st2_q.s1) * ProdW'(st2_q.k_inner);
    st3_d.p3  = ProdW'(st2_q.s3) * ProdW'(st2_q.k_inner);
    st3_d.p4  = ProdW'(st2_q.s4) * ProdW'(st2_q.k_outer);
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      st3_q <= st3_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage four: division by the sample full scale.
  // --------------------------------------------------------------------------
  localparam int unsigned RecipProdW = ProdW + 29;

  logic [RecipProdW-1:0] q0, q1, q3, q4;
  st4_t                  st4_d, st4_q;

  always_comb begin
    q0 = RecipProdW'(st3_q.p0) * RecipProdW'(RecipMul);
    q1 = RecipProdW'(st3_q.p1) * RecipProdW'(RecipMul);
    q3 = RecipProdW'(st3_q.p3) * RecipProdW'(RecipMul);
    q4 = RecipProdW'(st3_q.p4) * RecipProdW'(RecipMul);
    st4_d.ctl = st3_q.ctl;
    st4_d.a0  = q0[RecipShift +: ScaledW];
    st4_d.a1  = q1[RecipShift +: ScaledW];
    st4_d.a3  = q3[RecipShift +: ScaledW];
    st4_d.a4  = q4[RecipShift +: ScaledW];
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      st4_q <= st4_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage five: side sums, each held at the peak speed.
  // --------------------------------------------------------------------------
  logic [ScaledW:0] sum_left, sum_right;
  st56_t            st5_d, st5_q;

  always_comb begin
    sum_left  = (ScaledW+1)'(st4_q.a0) + (ScaledW+1)'(st4_q.a1);
    sum_right = (ScaledW+1)'(st4_q.a3) + (ScaledW+1)'(st4_q.a4);
    st5_d.ctl = st4_q.ctl;
    st5_d.lw  = (sum_left  > (ScaledW+1)'(st4_q.ctl.m)) ? st4_q.ctl.m : sum_left[7:0];
    st5_d.rw  = (sum_right > (ScaledW+1)'(st4_q.ctl.m)) ? st4_q.ctl.m : sum_right[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      st5_q <= st5_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage six: a strong left side cuts the right weight to three tenths.
  // --------------------------------------------------------------------------
  logic [11:0] lw_x10;
  st56_t       st6_d, st6_q;

  always_comb begin
    lw_x10    = 12'({st5_q.lw, 3'd0}) + 12'({st5_q.lw, 1'd0});
    st6_d     = st5_q;
    if (lw_x10 > 12'(st5_q.ctl.m8)) begin
      st6_d.rw = lfmd_pkg::div10(11'({st5_q.rw, 1'd0}) + 11'(st5_q.rw));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      st6_q <= st6_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage seven: the updated right side may cut the left weight, then the
  // weights become duties. This stage is the output register.
  // --------------------------------------------------------------------------
  logic [11:0] rw_x10;
  logic [7:0]  lw_cut;
  st7_t        st7_d, st7_q;

  always_comb begin
    rw_x10 = 12'({st6_q.rw, 3'd0}) + 12'({st6_q.rw, 1'd0});
    lw_cut = (rw_x10 > 12'(st6_q.ctl.m8))
           ? lfmd_pkg::div10(11'({st6_q.lw, 1'd0}) + 11'(st6_q.lw))
           : st6_q.lw;
    st7_d.ctl = st6_q.ctl;
    if (st6_q.ctl.digital) begin
      st7_d.right = st6_q.ctl.dig_right;
      st7_d.left  = st6_q.ctl.dig_left;
    end else if (st6_q.ctl.white) begin
      st7_d.right = st6_q.rw;
      st7_d.left  = lw_cut;
    end else begin
      st7_d.right = st6_q.ctl.m - st6_q.rw;
      st7_d.left  = st6_q.ctl.m - lw_cut;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      st7_q <= st7_d;
    end
  end

  assign out_o.valid        = vld_q[NumStages];
  assign out_o.right_drive  = st7_q.right;
  assign out_o.left_drive   = st7_q.left;
  assign out_o.line_pattern = st7_q.ctl.pattern;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The input only stalls when every stage holds a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&vld_q))
    else $error("input stalled while the pipeline has room");

  // A stage whose successor does not load keeps its transaction (checked for stage one).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[1] && !adv[2]) |=> vld_q[1])
    else $error("transaction dropped from stage one");

  // Analog results report no pattern.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !st7_q.ctl.digital) |-> (out_o.line_pattern == '0))
    else $error("pattern reported in analog mode");

  // Neither duty ever exceeds the peak speed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.right_drive <= st7_q.ctl.m && out_o.left_drive <= st7_q.ctl.m))
    else $error("drive above peak speed");

endmodule
`default_nettype wire
